FILE: hw/rtl/algs_pkg.sv
// ----------------------------------------------------------------------------
// algs_pkg
// Types, codes and constant tables of the ambient light auto gain sequencer.
// ----------------------------------------------------------------------------
package algs_pkg;

    // event kinds carried on the input tuser
    typedef enum logic [1:0] {
        CMD_START      = 2'd0,
        CMD_READ_DONE  = 2'd1,
        CMD_WRITE_DONE = 2'd2,
        CMD_DELAY_DONE = 2'd3
    } command_t;

    // requests and final results carried on the output tuser
    typedef enum logic [2:0] {
        ACT_READ  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_DELAY = 3'd2,
        ACT_ERROR = 3'd3,
        ACT_OK    = 3'd4
    } action_t;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_WAIT_PRE      = 4'd1,
        PH_READ_FIRST    = 4'd2,
        PH_WRITE_GAIN    = 4'd3,
        PH_WAIT_MID      = 4'd4,
        PH_READ_SECOND   = 4'd5,
        PH_WRITE_RESTORE = 4'd6,
        PH_WAIT_OVF      = 4'd7
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_GAIN_EIGHTH  = 2'd0;
    localparam logic [1:0] REG_GAIN_QUARTER = 2'd1;
    localparam logic [1:0] REG_GAIN_ONE     = 2'd2;
    localparam logic [1:0] REG_GAIN_TWO     = 2'd3;

    // gain times eight
    localparam logic [4:0] GAIN_EIGHTH  = 5'd1;
    localparam logic [4:0] GAIN_QUARTER = 5'd2;
    localparam logic [4:0] GAIN_ONE     = 5'd8;
    localparam logic [4:0] GAIN_TWO     = 5'd16;

    // reading thresholds
    localparam logic [15:0] LIMIT_DONE     = 16'h7000;
    localparam logic [15:0] LIMIT_QUARTER  = 16'h1000;
    localparam logic [15:0] LIMIT_ONE      = 16'h0500;
    localparam logic [15:0] READ_OVERFLOW  = 16'hFFFF;
    localparam logic [7:0]  TRIES_MAX      = 8'd255;

    // lux per count in Q0.16, rounded to nearest
    localparam logic [12:0] COEF_EIGHTH  = 13'd4404;
    localparam logic [12:0] COEF_QUARTER = 13'd2399;
    localparam logic [12:0] COEF_ONE     = 13'd551;
    localparam logic [12:0] COEF_TWO     = 13'd275;

    typedef struct packed {
        command_t    command;
        logic        wait_first;
        logic [15:0] read_value;
        logic        bus_error;
    } event_t;

    typedef struct packed {
        phase_t      phase;
        logic        wait_flag;
        logic [4:0]  gain;
        logic [7:0]  tries;
        logic [15:0] held;
    } seq_state_t;

    typedef struct packed {
        logic [15:0] eighth;
        logic [15:0] quarter;
        logic [15:0] one;
        logic [15:0] two;
    } cfg_words_t;

    typedef struct packed {
        logic        valid;
        action_t     action;
        logic [15:0] write_word;
        logic [28:0] lux_q16;
        logic [4:0]  gain_x8;
        logic [7:0]  tries;
    } result_t;

    // coefficient for the gain of a reading
    function automatic logic [12:0] coef_of(input logic [4:0] gain);
        logic [12:0] c;
        case (gain)
            GAIN_EIGHTH:  c = COEF_EIGHTH;
            GAIN_QUARTER: c = COEF_QUARTER;
            GAIN_ONE:     c = COEF_ONE;
            default:      c = COEF_TWO;
        endcase
        return c;
    endfunction

    // gain chosen from a first reading below the done limit
    function automatic logic [4:0] pick_gain(input logic [15:0] value);
        logic [4:0] g;
        if (value >= LIMIT_QUARTER)
        begin
            g = GAIN_QUARTER;
        end
        else if (value >= LIMIT_ONE)
        begin
            g = GAIN_ONE;
        end
        else
        begin
            g = GAIN_TWO;
        end
        return g;
    endfunction

    // saturating try counter
    function automatic logic [7:0] bump_tries(input logic [7:0] tries);
        return (tries < TRIES_MAX) ? tries + 8'd1 : tries;
    endfunction

endpackage

FILE: hw/rtl/algs_step.sv
// ----------------------------------------------------------------------------
// algs_step
// Next state and result of the sequencer for one event, with the lux multiply.
// ----------------------------------------------------------------------------
module algs_step
    import algs_pkg::*;
(
    input  seq_state_t cur,
    input  event_t     ev,
    input  cfg_words_t words,
    output seq_state_t nxt,
    output result_t    res
);

    logic [15:0] lux_value;
    logic [28:0] product;
    logic [4:0]  new_gain;
    logic        emit;
    action_t     act;
    logic [15:0] word;
    logic        lux_en;

    // the first reading is converted straight from the event, the second from the hold
    assign lux_value = (cur.phase == PH_READ_FIRST) ? ev.read_value : cur.held;
    assign product   = {13'd0, lux_value} * {16'd0, coef_of(cur.gain)};
    assign new_gain  = pick_gain(ev.read_value);

    // phase transitions
    always_comb
    begin
        nxt    = cur;
        emit   = 1'b0;
        act    = ACT_READ;
        word   = '0;
        lux_en = 1'b0;
        if (ev.command == CMD_START)
        begin
            nxt.gain      = GAIN_EIGHTH;
            nxt.tries     = 8'd1;
            nxt.wait_flag = ev.wait_first;
            emit          = 1'b1;
            if (ev.wait_first)
            begin
                nxt.phase = PH_WAIT_PRE;
                act       = ACT_DELAY;
            end
            else
            begin
                nxt.phase = PH_READ_FIRST;
                act       = ACT_READ;
            end
        end
        else
        begin
            case (cur.phase)
                PH_WAIT_PRE:
                begin
                    if (ev.command == CMD_DELAY_DONE)
                    begin
                        nxt.phase = PH_READ_FIRST;
                        emit      = 1'b1;
                        act       = ACT_READ;
                    end
                end
                PH_READ_FIRST:
                begin
                    if (ev.command == CMD_READ_DONE)
                    begin
                        emit = 1'b1;
                        if (ev.bus_error)
                        begin
                            nxt.phase = PH_IDLE;
                            act       = ACT_ERROR;
                        end
                        else if (ev.read_value >= LIMIT_DONE)
                        begin
                            nxt.phase = PH_IDLE;
                            act       = ACT_OK;
                            lux_en    = 1'b1;
                        end
                        else
                        begin
                            nxt.tries = bump_tries(cur.tries);
                            nxt.gain  = new_gain;
                            nxt.phase = PH_WRITE_GAIN;
                            act       = ACT_WRITE;
                            case (new_gain)
                                GAIN_QUARTER: word = words.quarter;
                                GAIN_ONE:     word = words.one;
                                GAIN_TWO:     word = words.two;
                                default:      word = words.eighth;
                            endcase
                        end
                    end
                end
                PH_WRITE_GAIN:
                begin
                    if (ev.command == CMD_WRITE_DONE)
                    begin
                        emit = 1'b1;
                        if (ev.bus_error)
                        begin
                            nxt.phase = PH_IDLE;
                            act       = ACT_ERROR;
                        end
                        else
                        begin
                            nxt.phase = PH_WAIT_MID;
                            act       = ACT_DELAY;
                        end
                    end
                end
                PH_WAIT_MID:
                begin
                    if (ev.command == CMD_DELAY_DONE)
                    begin
                        nxt.phase = PH_READ_SECOND;
                        emit      = 1'b1;
                        act       = ACT_READ;
                    end
                end
                PH_READ_SECOND:
                begin
                    if (ev.command == CMD_READ_DONE)
                    begin
                        emit = 1'b1;
                        if (ev.bus_error)
                        begin
                            nxt.phase = PH_IDLE;
                            act       = ACT_ERROR;
                        end
                        else
                        begin
                            nxt.held  = ev.read_value;
                            nxt.phase = PH_WRITE_RESTORE;
                            act       = ACT_WRITE;
                            word      = words.eighth;
                        end
                    end
                end
                PH_WRITE_RESTORE:
                begin
                    if (ev.command == CMD_WRITE_DONE)
                    begin
                        emit = 1'b1;
                        if (ev.bus_error)
                        begin
                            nxt.phase = PH_IDLE;
                            act       = ACT_ERROR;
                        end
                        else if (cur.held == READ_OVERFLOW)
                        begin
                            nxt.gain  = GAIN_EIGHTH;
                            nxt.tries = bump_tries(cur.tries);
                            nxt.phase = PH_WAIT_OVF;
                            act       = ACT_DELAY;
                        end
                        else
                        begin
                            nxt.phase = PH_IDLE;
                            act       = ACT_OK;
                            lux_en    = 1'b1;
                        end
                    end
                end
                PH_WAIT_OVF:
                begin
                    if (ev.command == CMD_DELAY_DONE)
                    begin
                        emit = 1'b1;
                        if (cur.wait_flag)
                        begin
                            nxt.phase = PH_WAIT_PRE;
                            act       = ACT_DELAY;
                        end
                        else
                        begin
                            nxt.phase = PH_READ_FIRST;
                            act       = ACT_READ;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // result carries gain and tries after the update
    always_comb
    begin
        res.valid      = emit;
        res.action     = act;
        res.write_word = word;
        res.lux_q16    = lux_en ? product : '0;
        res.gain_x8    = nxt.gain;
        res.tries      = nxt.tries;
    end

endmodule

FILE: hw/rtl/ambient_light_auto_gain_sequencer.sv
// ----------------------------------------------------------------------------
// ambient_light_auto_gain_sequencer
// Auto-ranging ambient light measurement sequencer driven by bus events.
// ----------------------------------------------------------------------------
// Each event on the input stream is taken into an input register and handled by
// one pass of the step logic (phase update and the 16 x 13 bit lux multiply),
// which loads the result register once that register is free or being drained;
// one event is accepted every cycle as long as the result register is free or
// being drained. Events that do not fit the current phase give no result and
// never wait on the output. The four config words are to be written through the
// plain write port only while idle; the block itself does not enforce it.
module ambient_light_auto_gain_sequencer
    import algs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // wait_first, read_value[15:0], bus_error, zero fill
    input  logic [1:0]  s_tuser,   // command
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // write_word[15:0], lux_q16[28:0], gain_x8[4:0],
                                   // tries[7:0], zero fill
    output logic [2:0]  m_tuser,   // action
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic       in_valid_reg;
    event_t     in_ev_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    cfg_words_t words_reg;
    result_t    step_res;
    logic       advance;

    // step for the registered event
    algs_step u_step (
        .cur   (state_reg),
        .ev    (in_ev_reg),
        .words (words_reg),
        .nxt   (state_next),
        .res   (step_res)
    );

    // an event moves on when its result has room or it has no result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !step_res.valid);
    assign s_tready = !in_valid_reg || advance;

    // config word registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GAIN_EIGHTH:  words_reg.eighth  <= cfg_wdata;
                REG_GAIN_QUARTER: words_reg.quarter <= cfg_wdata;
                REG_GAIN_ONE:     words_reg.one     <= cfg_wdata;
                REG_GAIN_TWO:     words_reg.two     <= cfg_wdata;
                default:          words_reg         <= words_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ev_reg.command    <= command_t'(s_tuser);
            in_ev_reg.wait_first <= s_tdata[0];
            in_ev_reg.read_value <= s_tdata[16:1];
            in_ev_reg.bus_error  <= s_tdata[17];
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_IDLE;
            state_reg.wait_flag <= 1'b0;
            state_reg.gain      <= GAIN_EIGHTH;
            state_reg.tries     <= 8'd1;
            state_reg.held      <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step_res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.valid)
        begin
            out_res_reg <= step_res;
        end
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {6'd0, out_res_reg.tries, out_res_reg.gain_x8,
                       out_res_reg.lux_q16, out_res_reg.write_word};

`ifndef SYNTHESIS
    // gain is always one of the four ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.gain == GAIN_EIGHTH) || (state_reg.gain == GAIN_QUARTER) ||
        (state_reg.gain == GAIN_ONE) || (state_reg.gain == GAIN_TWO))
        else $error("gain register holds an unknown range");

    // try count never drops to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.tries != 8'd0)
        else $error("try count is zero");

    // a finished result returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.valid &&
        (step_res.action == ACT_ERROR || step_res.action == ACT_OK)
        |=> state_reg.phase == PH_IDLE)
        else $error("sequencer not idle after a finished result");

    // a held result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result changed");
`endif

endmodule

FILE: test/tb_ambient_light_auto_gain_sequencer.sv
// ----------------------------------------------------------------------------
// tb_ambient_light_auto_gain_sequencer
// Self-checking bench for the auto gain sequencer. Directed event sequences
// cover the finish paths, the gain thresholds, overflow restart and bus
// faults. Random measurement runs with noise and a long overflow chase up to
// the try limit follow. Every result is checked against a behavioral
// predictor of the phase machine and the lux arithmetic.
// ----------------------------------------------------------------------------
module tb_ambient_light_auto_gain_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import algs_pkg::*;

    // one expected result
    typedef struct packed {
        action_t     action;
        logic [15:0] write_word;
        logic [28:0] lux_q16;
        logic [4:0]  gain_x8;
        logic [7:0]  tries;
    } reply_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        FLOW_OPEN,
        FLOW_COIN,
        FLOW_SPARSE,
        FLOW_WAVE
    } flow_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;        // wait_first, read_value[15:0], bus_error, zero fill
    logic [1:0]  s_tuser   = CMD_START; // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;               // write_word[15:0], lux_q16[28:0], gain_x8[4:0],
                                        // tries[7:0], zero fill
    logic [2:0]  m_tuser;               // action
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = REG_GAIN_EIGHTH;
    logic [15:0] cfg_wdata = '0;

    // predictor state, reset values
    phase_t      seq_phase = PH_IDLE;
    logic        seq_wait  = 1'b0;
    logic [4:0]  seq_gain  = GAIN_EIGHTH;
    logic [7:0]  seq_tries = 8'd1;
    logic [15:0] seq_held  = '0;
    logic [15:0] cfg_words [4] = '{default: 16'h0000};

    reply_t      replies_due [$];
    int unsigned replies_issued = 0;
    int unsigned burst_left     = 0;
    int          errors_seen    = 0;

    ambient_light_auto_gain_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lux in Q13.16: count times the per-gain Q0.16 coefficient
    function automatic logic [28:0] lux_of_reading(input logic [15:0] value,
                                                   input logic [4:0] gain);
        logic [12:0] coef;
        logic [31:0] product;
        case (gain)
            GAIN_EIGHTH:  coef = COEF_EIGHTH;
            GAIN_QUARTER: coef = COEF_QUARTER;
            GAIN_ONE:     coef = COEF_ONE;
            default:      coef = COEF_TWO;
        endcase
        product = 32'(value) * 32'(coef);
        return product[28:0];
    endfunction

    // sensor config word for a gain
    function automatic logic [15:0] word_of_gain(input logic [4:0] gain);
        logic [15:0] w;
        case (gain)
            GAIN_QUARTER: w = cfg_words[REG_GAIN_QUARTER];
            GAIN_ONE:     w = cfg_words[REG_GAIN_ONE];
            GAIN_TWO:     w = cfg_words[REG_GAIN_TWO];
            default:      w = cfg_words[REG_GAIN_EIGHTH];
        endcase
        return w;
    endfunction

    // record a result carrying the current gain and round count
    function automatic void queue_reply(input action_t act, input logic [15:0] word,
                                        input logic [28:0] lux);
        reply_t r;
        r.action     = act;
        r.write_word = word;
        r.lux_q16    = lux;
        r.gain_x8    = seq_gain;
        r.tries      = seq_tries;
        replies_due.push_back(r);
        replies_issued++;
    endfunction

    // saturating round counter
    function automatic void count_round();
        if (seq_tries != TRIES_MAX)
            seq_tries = seq_tries + 8'd1;
    endfunction

    // bus fault: error result and back to idle
    function automatic void abort_run();
        seq_phase = PH_IDLE;
        queue_reply(ACT_ERROR, 16'h0000, 29'd0);
    endfunction

    // advance the predicted sequencer by one accepted event
    function automatic void predict_event(input command_t cmd, input logic wf,
                                          input logic [15:0] val, input logic err);
        if (cmd == CMD_START)
        begin
            seq_gain  = GAIN_EIGHTH;
            seq_tries = 8'd1;
            seq_wait  = wf;
            seq_phase = wf ? PH_WAIT_PRE : PH_READ_FIRST;
            queue_reply(wf ? ACT_DELAY : ACT_READ, 16'h0000, 29'd0);
        end
        else
        begin
            case (seq_phase)
                PH_WAIT_PRE, PH_WAIT_MID:
                begin
                    if (cmd == CMD_DELAY_DONE)
                    begin
                        seq_phase = (seq_phase == PH_WAIT_PRE) ? PH_READ_FIRST : PH_READ_SECOND;
                        queue_reply(ACT_READ, 16'h0000, 29'd0);
                    end
                end
                PH_READ_FIRST:
                begin
                    if (cmd == CMD_READ_DONE)
                    begin
                        if (err)
                            abort_run();
                        else if (val >= LIMIT_DONE)
                        begin
                            seq_phase = PH_IDLE;
                            queue_reply(ACT_OK, 16'h0000, lux_of_reading(val, seq_gain));
                        end
                        else
                        begin
                            count_round();
                            seq_gain  = (val >= LIMIT_QUARTER) ? GAIN_QUARTER :
                                        (val >= LIMIT_ONE)     ? GAIN_ONE : GAIN_TWO;
                            seq_phase = PH_WRITE_GAIN;
                            queue_reply(ACT_WRITE, word_of_gain(seq_gain), 29'd0);
                        end
                    end
                end
                PH_WRITE_GAIN:
                begin
                    if (cmd == CMD_WRITE_DONE)
                    begin
                        if (err)
                            abort_run();
                        else
                        begin
                            seq_phase = PH_WAIT_MID;
                            queue_reply(ACT_DELAY, 16'h0000, 29'd0);
                        end
                    end
                end
                PH_READ_SECOND:
                begin
                    if (cmd == CMD_READ_DONE)
                    begin
                        if (err)
                            abort_run();
                        else
                        begin
                            seq_held  = val;
                            seq_phase = PH_WRITE_RESTORE;
                            queue_reply(ACT_WRITE, cfg_words[REG_GAIN_EIGHTH], 29'd0);
                        end
                    end
                end
                PH_WRITE_RESTORE:
                begin
                    if (cmd == CMD_WRITE_DONE)
                    begin
                        if (err)
                            abort_run();
                        else if (seq_held == READ_OVERFLOW)
                        begin
                            seq_gain = GAIN_EIGHTH;
                            count_round();
                            seq_phase = PH_WAIT_OVF;
                            queue_reply(ACT_DELAY, 16'h0000, 29'd0);
                        end
                        else
                        begin
                            seq_phase = PH_IDLE;
                            queue_reply(ACT_OK, 16'h0000, lux_of_reading(seq_held, seq_gain));
                        end
                    end
                end
                PH_WAIT_OVF:
                begin
                    if (cmd == CMD_DELAY_DONE)
                    begin
                        seq_phase = seq_wait ? PH_WAIT_PRE : PH_READ_FIRST;
                        queue_reply(seq_wait ? ACT_DELAY : ACT_READ, 16'h0000, 29'd0);
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // one event transfer, with bursts and random gaps on the sender side
    task automatic send_event(input command_t cmd, input logic wf, input logic [15:0] val,
                              input logic err);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, err, val, wf};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        predict_event(cmd, wf, val, err);
    endtask

    // stop sending and wait for every outstanding result, then idle
    task automatic settle(input int unsigned extra);
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (replies_due.size() != 0)
        begin
            $error("%0d expected results never arrived", replies_due.size());
            errors_seen++;
            replies_due.delete();
        end
        repeat (extra) @(posedge clk);
    endtask

    // single register write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_words[idx] = value;
    endtask

    // load all four config words while idle
    task automatic set_words(input logic [15:0] w_eighth, input logic [15:0] w_quarter,
                             input logic [15:0] w_one, input logic [15:0] w_two);
        write_reg(REG_GAIN_EIGHTH, w_eighth);
        write_reg(REG_GAIN_QUARTER, w_quarter);
        write_reg(REG_GAIN_ONE, w_one);
        write_reg(REG_GAIN_TWO, w_two);
        cfg_we <= 1'b0;
    endtask

    // first reading: some finish at once, some sit on the thresholds
    function automatic logic [15:0] first_reading(input bit chase);
        logic [15:0] pick;
        if (chase)
            pick = 16'($urandom_range(0, LIMIT_DONE - 16'd1));
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:    pick = 16'($urandom_range(LIMIT_DONE, READ_OVERFLOW));
                2:       pick = LIMIT_DONE - 16'd1 + 16'($urandom_range(0, 1));
                3:       pick = LIMIT_QUARTER - 16'd1 + 16'($urandom_range(0, 1));
                4:       pick = LIMIT_ONE - 16'd1 + 16'($urandom_range(0, 1));
                default: pick = 16'($urandom_range(0, LIMIT_DONE - 16'd1));
            endcase
        end
        return pick;
    endfunction

    // next event: mostly the one the current phase waits for, sometimes noise
    task automatic pick_event(input bit chase, output command_t cmd, output logic wf,
                              output logic [15:0] val, output logic err);
        cmd = CMD_START;
        wf  = 1'($urandom_range(0, 1));
        val = 16'($urandom);
        err = 1'($urandom_range(0, 1));
        if (!chase && $urandom_range(0, 99) < 6)
            cmd = command_t'($urandom_range(0, 3));
        else
        begin
            case (seq_phase)
                PH_IDLE:
                    cmd = CMD_START;
                PH_WAIT_PRE, PH_WAIT_MID, PH_WAIT_OVF:
                    cmd = CMD_DELAY_DONE;
                PH_READ_FIRST:
                begin
                    cmd = CMD_READ_DONE;
                    val = first_reading(chase);
                    err = !chase && ($urandom_range(0, 99) < 5);
                end
                PH_READ_SECOND:
                begin
                    cmd = CMD_READ_DONE;
                    if (chase)
                        val = (seq_tries != TRIES_MAX || $urandom_range(0, 2) != 0)
                              ? READ_OVERFLOW : 16'($urandom);
                    else if ($urandom_range(0, 6) == 0)
                        val = READ_OVERFLOW;
                    err = !chase && ($urandom_range(0, 99) < 5);
                end
                default:
                begin
                    cmd = CMD_WRITE_DONE;
                    err = !chase && ($urandom_range(0, 99) < 5);
                end
            endcase
        end
    endtask

    // report one field mismatch
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors_seen++;
        end
    endtask

    // bright light finishes at gain one eighth, with and without the first delay
    task automatic test_quick_finish();
        send_event(CMD_START, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, 16'hFFFF, 1'b0);
        send_event(CMD_START, 1'b1, 16'hFFFF, 1'b1);
        send_event(CMD_DELAY_DONE, 1'b1, 16'h0000, 1'b1);
        send_event(CMD_READ_DONE, 1'b1, LIMIT_DONE, 1'b0);
    endtask

    // gain picks on both sides of the quarter threshold, restart while busy, zero second reading
    task automatic test_gain_thresholds();
        send_event(CMD_START, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, LIMIT_QUARTER, 1'b0);
        send_event(CMD_START, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, LIMIT_QUARTER - 16'd1, 1'b0);
        send_event(CMD_WRITE_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_DELAY_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_WRITE_DONE, 1'b0, 16'h0000, 1'b0);
    endtask

    // overflow on the second reading restarts the loop, through the first delay
    task automatic test_overflow_restart();
        send_event(CMD_START, 1'b1, 16'h0000, 1'b0);
        send_event(CMD_DELAY_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, LIMIT_ONE - 16'd1, 1'b0);
        send_event(CMD_WRITE_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_DELAY_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, READ_OVERFLOW, 1'b0);
        send_event(CMD_WRITE_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_DELAY_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_DELAY_DONE, 1'b0, 16'h0000, 1'b0);
        send_event(CMD_READ_DONE, 1'b0, LIMIT_ONE, 1'b0);
    endtask

    // read fault, ignored fault flag on start, stray event in idle
    task automatic test_faults_and_noise();
        send_event(CMD_START, 1'b0, 16'h0000, 1'b1);
        send_event(CMD_READ_DONE, 1'b0, 16'h1234, 1'b1);
        send_event(CMD_READ_DONE, 1'b1, 16'h0100, 1'b0);
    endtask

    // random runs under several config settings, extremes first
    task automatic test_random_runs();
        command_t    cmd;
        logic        wf;
        logic [15:0] val;
        logic        err;
        int unsigned target;
        for (int round = 0; round < 5; round++)
        begin
            settle(4);
            case (round)
                0:       set_words(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1:       set_words(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_words(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            target = replies_issued + 90;
            while (replies_issued < target)
            begin
                pick_event(1'b0, cmd, wf, val, err);
                send_event(cmd, wf, val, err);
            end
        end
    endtask

    // keep overflowing until the round count sits at its limit, then finish
    task automatic test_tries_saturate();
        command_t    cmd;
        logic        wf;
        logic [15:0] val;
        logic        err;
        settle(4);
        set_words(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_event(CMD_START, 1'($urandom_range(0, 1)), 16'($urandom), 1'b0);
        while (!(seq_phase == PH_IDLE && seq_tries == TRIES_MAX))
        begin
            pick_event(1'b1, cmd, wf, val, err);
            send_event(cmd, wf, val, err);
        end
    endtask

    // result checking and receiver stalls
    initial
    begin : result_check
        reply_t      want;
        flow_t       flow;
        int unsigned flow_left;
        int unsigned tick;
        flow      = FLOW_OPEN;
        flow_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            // a completed result transfer against the oldest expectation
            if (m_tvalid === 1'b1 && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result with nothing expected: action %0d", m_tuser);
                    errors_seen++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("action", 32'(want.action), 32'(m_tuser));
                    check_field("write_word", 32'(want.write_word), 32'(m_tdata[15:0]));
                    check_field("lux_q16", 32'(want.lux_q16), 32'(m_tdata[44:16]));
                    check_field("gain_x8", 32'(want.gain_x8), 32'(m_tdata[49:45]));
                    check_field("tries", 32'(want.tries), 32'(m_tdata[57:50]));
                end
            end
            // stall pattern, picked anew when the current run is used up
            if (flow_left == 0)
            begin
                flow      = flow_t'($urandom_range(0, 3));
                flow_left = $urandom_range(8, 80);
            end
            flow_left--;
            tick++;
            case (flow)
                FLOW_OPEN:   m_tready <= 1'b1;
                FLOW_COIN:   m_tready <= 1'($urandom_range(0, 1));
                FLOW_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= (tick % 6) < 3;
            endcase
        end
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_words(16'h1357, 16'h2468, 16'h9BDF, 16'hACE0);
        test_quick_finish();
        test_gain_thresholds();
        test_overflow_restart();
        test_faults_and_noise();
        test_random_runs();
        test_tries_saturate();
        settle(8);
        if (errors_seen == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
